/* src/array_list_engine_unit_assert.svh */
// Assertion macros for the list engine.
`ifndef ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH
`define ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define ALE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ALE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* src/ale_pkg.sv */
package ale_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_INSERT    = 3'd1,
    CMD_ERASE_CNT = 3'd2,
    CMD_ERASE_RNG = 3'd3,
    CMD_READ      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_RANGE  = 2'd3
  } st_e;

  typedef struct packed {
    logic [2:0]               cmd;
    logic [7:0]               pos;
    logic signed [DATA_W-1:0] value;
    logic [7:0]               cnt;
    logic [7:0]               rng_end;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    st_e                      status;
    logic [7:0]               element_count;
    logic                     is_empty;
  } res_t;

endpackage

/* src/ale_mem.sv */
module ale_mem #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [ale_pkg::DATA_W-1:0]    wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [ale_pkg::DATA_W-1:0]    rdata_o
);
  import ale_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ale_seq.sv */
module ale_seq #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ale_pkg::req_t                   req_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output ale_pkg::res_t                   res_o,
  output logic                            mem_we_o,
  output logic [$clog2(CAPACITY)-1:0]     mem_waddr_o,
  output logic [ale_pkg::DATA_W-1:0]      mem_wdata_o,
  output logic                            mem_re_o,
  output logic [$clog2(CAPACITY)-1:0]     mem_raddr_o,
  input  logic [ale_pkg::DATA_W-1:0]      mem_rdata_i
);
  import ale_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 8) ? CW : 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_READ,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     src_q;
  logic [CW-1:0]     n_q;
  logic [CW-1:0]     gap_q;
  logic [AW-1:0]     dst_q;
  logic [AW-1:0]     ins_addr_q;
  logic              pend_q;
  logic              up_q;
  logic              ins_q;
  logic [DATA_W-1:0] val_q;
  res_t              res_q;

  logic              accept;
  logic              full;
  logic [CMPW-1:0]   pos_x, end_x, cnt_x, count_x;
  logic [CMPW-1:0]   left_x, clamp_x, rem_x, sum_x, span_x, tail_x;
  logic [CMPW-1:0]   newcnt_x;
  logic [CW-1:0]     src_up, src_dn;

  st_e               dec_status;
  logic [CW-1:0]     dec_count, dec_src, dec_n, dec_gap;
  logic              dec_move, dec_read, dec_app, dec_up, dec_ins;

  assign accept  = in_valid_i && in_ready_o;
  assign full    = (count_q == CW'(CAPACITY));
  assign pos_x   = CMPW'(req_i.pos);
  assign end_x   = CMPW'(req_i.rng_end);
  assign cnt_x   = CMPW'(req_i.cnt);
  assign count_x = CMPW'(count_q);
  assign left_x  = count_x - pos_x;
  assign clamp_x = (cnt_x > left_x) ? left_x : cnt_x;
  assign rem_x   = left_x - clamp_x;
  assign sum_x   = pos_x + clamp_x;
  assign span_x  = end_x - pos_x;
  assign tail_x  = count_x - end_x;
  assign src_up  = src_q + CW'(1);
  assign src_dn  = src_q - gap_q;

  // Command decode against the current count.
  always_comb begin
    dec_status = ST_OK;
    dec_count  = count_q;
    dec_src    = '0;
    dec_n      = '0;
    dec_gap    = '0;
    dec_move   = 1'b0;
    dec_read   = 1'b0;
    dec_app    = 1'b0;
    dec_up     = 1'b0;
    dec_ins    = 1'b0;
    unique case (cmd_e'(req_i.cmd))
      CMD_APPEND: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_app   = 1'b1;
          dec_count = count_q + CW'(1);
        end
      end
      CMD_INSERT: begin
        if (full) begin
          dec_status = ST_FULL;
        end else if (pos_x > count_x) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_move  = 1'b1;
          dec_up    = 1'b1;
          dec_ins   = 1'b1;
          dec_src   = count_q - CW'(1);
          dec_n     = left_x[CW-1:0];
          dec_count = count_q + CW'(1);
        end
      end
      CMD_ERASE_CNT: begin
        if (pos_x >= count_x) begin
          dec_status = ST_BADPOS;
        end else if (clamp_x != '0) begin
          dec_move  = 1'b1;
          dec_gap   = clamp_x[CW-1:0];
          dec_src   = sum_x[CW-1:0];
          dec_n     = rem_x[CW-1:0];
          dec_count = count_q - clamp_x[CW-1:0];
        end
      end
      CMD_ERASE_RNG: begin
        if (pos_x < count_x && end_x <= count_x && pos_x < end_x) begin
          dec_move  = 1'b1;
          dec_gap   = span_x[CW-1:0];
          dec_src   = end_x[CW-1:0];
          dec_n     = tail_x[CW-1:0];
          dec_count = count_q - span_x[CW-1:0];
        end else begin
          dec_status = ST_BADPOS;
        end
      end
      CMD_READ: begin
        if (pos_x < count_x) begin
          dec_read = 1'b1;
        end else begin
          dec_status = ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  assign newcnt_x = CMPW'(dec_count);

  // Memory port steering: one read and one write per cycle.
  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = src_q[AW-1:0];
    mem_we_o    = 1'b0;
    mem_waddr_o = dst_q;
    mem_wdata_o = mem_rdata_i;
    if (state_q == S_IDLE) begin
      mem_re_o    = accept && dec_read;
      mem_raddr_o = pos_x[AW-1:0];
      mem_we_o    = accept && dec_app;
      mem_waddr_o = count_q[AW-1:0];
      mem_wdata_o = req_i.value;
    end else if (state_q == S_MOVE) begin
      mem_re_o = (n_q != '0);
      if (pend_q) begin
        mem_we_o = 1'b1;
      end else if (n_q == '0 && ins_q) begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ins_addr_q;
        mem_wdata_o = val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      src_q      <= '0;
      n_q        <= '0;
      gap_q      <= '0;
      dst_q      <= '0;
      ins_addr_q <= '0;
      pend_q     <= 1'b0;
      up_q       <= 1'b0;
      ins_q      <= 1'b0;
      val_q      <= '0;
      res_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            count_q             <= dec_count;
            res_q.read_value    <= '0;
            res_q.status        <= dec_status;
            res_q.element_count <= newcnt_x[7:0];
            res_q.is_empty      <= (dec_count == '0);
            src_q               <= dec_src;
            n_q                 <= dec_n;
            gap_q               <= dec_gap;
            up_q                <= dec_up;
            ins_q               <= dec_ins;
            ins_addr_q          <= pos_x[AW-1:0];
            val_q               <= req_i.value;
            pend_q              <= 1'b0;
            if (dec_move) begin
              state_q <= S_MOVE;
            end else if (dec_read) begin
              state_q <= S_READ;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_MOVE: begin
          pend_q <= (n_q != '0);
          if (n_q != '0) begin
            src_q <= up_q ? src_q - CW'(1) : src_up;
            n_q   <= n_q - CW'(1);
            dst_q <= up_q ? src_up[AW-1:0] : src_dn[AW-1:0];
          end else if (!pend_q) begin
            state_q <= S_DONE;
          end
        end
        S_READ: begin
          res_q.read_value <= mem_rdata_i;
          state_q          <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

/* src/array_list_engine_unit.sv */
// An accepted item is decoded on acceptance, then runs the shift loop (S_MOVE) or the
// registered read (S_READ) where it needs one, then waits in S_DONE until its result
// is handed to the output register; only then is the next item taken. Throughput: one
// item at a time; the entry memory moves one entry per cycle, so long shifts dominate.
// Reset: asynchronous, active low; clears entry count and handshake state, not memory.
module array_list_engine_unit #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] position, [39:8] element_value, [47:40] erase_count, [55:48] range_end
  input  logic [55:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] read_value, [33:32] status, [41:34] element_count, [42] is_empty,
  // [47:43] zero
  output logic [47:0] m_axis_tdata
);
  import ale_pkg::*;

  `include "array_list_engine_unit_assert.svh"

  localparam int unsigned AW = $clog2(CAPACITY);

  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              res_ready;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  // Output register: the sequencer hands off a finished item here and may
  // take the next command while this one waits downstream.
  logic              out_vld_q;
  res_t              out_q;

  // Unpack the input item.
  assign req.cmd     = s_axis_tuser;
  assign req.pos     = s_axis_tdata[7:0];
  assign req.value   = s_axis_tdata[39:8];
  assign req.cnt     = s_axis_tdata[47:40];
  assign req.rng_end = s_axis_tdata[55:48];

  // Control sequencer: decode, shift loop, count tracking.
  ale_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Entry storage, one write and one registered read per cycle.
  ale_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      if (res_valid && res_ready) begin
        out_vld_q <= 1'b1;
        out_q     <= res;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_q.is_empty, out_q.element_count, out_q.status,
                          out_q.read_value};

  // The sequencer is never ready in the cycle after it accepts a command.
  `ALE_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A handed-off result shows up on the output channel next cycle.
  `ALE_ASSERT_NXT(a_handoff_shows, clk_i, rst_ni, res_valid && res_ready, m_axis_tvalid)
  // A blocked result stays offered and unchanged in the sequencer.
  `ALE_ASSERT_NXT(a_res_holds, clk_i, rst_ni, res_valid && !res_ready, res_valid && $stable(res))

endmodule

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ale_pkg::*;

  localparam int unsigned CAPACITY   = 128;
  localparam int unsigned HOLD_AFTER = 400;  // results seen before the long receiver hold-off
  localparam int unsigned LONG_HOLD  = 500;  // cycles of that hold-off
  localparam int unsigned RAND_ITEMS = 900;
  localparam int unsigned PHASE_LEN  = 150;  // items per grow or shrink phase
  localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;

  typedef enum int unsigned {RX_STREAM, RX_RANDOM, RX_SPARSE} rx_mode_e;

  typedef struct {
    logic [31:0] read_value;
    st_e         status;
    logic [7:0]  element_count;
    logic        is_empty;
  } list_result_t;

  // Shadow copy of the list; predicts one result per accepted command.
  class list_shadow;
    logic [31:0]  entries[CAPACITY];
    int unsigned  fill;
    list_result_t pending[$];
    int unsigned  errors;

    function void drop_entries(int unsigned from, int unsigned gap);
      int unsigned i;
      for (i = from; i + gap < fill; i++) entries[i] = entries[i + gap];
      fill -= gap;
    endfunction

    function void apply_command(logic [2:0] cmd, logic [7:0] pos, logic [31:0] value,
                                logic [7:0] cnt, logic [7:0] rng_end);
      list_result_t r;
      int unsigned  i;
      int unsigned  n;
      r.read_value = '0;
      r.status     = ST_OK;
      case (cmd)
        CMD_APPEND: begin
          if (fill < CAPACITY) begin
            entries[fill] = value;
            fill++;
          end else begin
            r.status = ST_FULL;
          end
        end
        CMD_INSERT: begin
          // full is checked ahead of the position
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else if (pos > fill) begin
            r.status = ST_BADPOS;
          end else begin
            for (i = fill; i > pos; i--) entries[i] = entries[i - 1];
            entries[pos] = value;
            fill++;
          end
        end
        CMD_ERASE_CNT: begin
          if (pos >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            n = (cnt > fill - pos) ? fill - pos : cnt;  // clamp to the tail
            if (n > 0) drop_entries(pos, n);
          end
        end
        CMD_ERASE_RNG: begin
          if (pos < fill && rng_end <= fill && pos < rng_end) begin
            drop_entries(pos, rng_end - pos);
          end else begin
            r.status = ST_BADPOS;
          end
        end
        CMD_READ: begin
          if (pos < fill) begin
            r.read_value = entries[pos];
          end else begin
            r.status = ST_RANGE;
          end
        end
        default: ;  // spare codes leave the list alone
      endcase
      r.element_count = fill[7:0];
      r.is_empty      = (fill == 0);
      pending = {pending, r};
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [47:0] data);
      list_result_t want;
      if (pending.size() == 0) begin
        $error("result item with no command outstanding: 0x%0h", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      check_field("read_value", want.read_value, data[31:0]);
      check_field("status", want.status, data[33:32]);
      check_field("element_count", want.element_count, data[41:34]);
      check_field("is_empty", want.is_empty, data[42]);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // [7:0] position, [39:8] value, [47:40] count, [55:48] end
  logic [2:0]  s_axis_tuser;   // [2:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [31:0] read_value, [33:32] status, [41:34] count, [42] empty

  list_shadow  shadow = new();
  int unsigned results_seen;
  int unsigned burst_left;

  array_list_engine_unit #(.CAPACITY(CAPACITY)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end

  // Result monitor: old values are sampled at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      shadow.check_result(m_axis_tdata);
      results_seen++;
    end
  end

  // Receiver: random stretches of streaming, coin-flip and sparse ready, plus one long
  // hold-off so the engine backs up and stalls its input.
  initial begin
    rx_mode_e    mode;
    int unsigned seg;
    bit          held_off;
    held_off = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = rx_mode_e'($urandom_range(2, 0));
      seg  = $urandom_range(60, 1);
      repeat (seg) begin
        @(posedge clk_i);
        if (!held_off && results_seen >= HOLD_AFTER) begin
          held_off = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
        end
        case (mode)
          RX_STREAM: m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= 1'($urandom_range(1, 0));
          default:   m_axis_tready <= ($urandom_range(7, 0) == 0);
        endcase
      end
    end
  end

  // Offer one item, wait for the handshake, then maybe close the burst with a gap.
  task automatic offer(input logic [2:0] cmd, input int unsigned pos,
                       input logic [31:0] value, input int unsigned cnt,
                       input int unsigned rng_end);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {rng_end[7:0], cnt[7:0], value, pos[7:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.apply_command(cmd, pos[7:0], value, cnt[7:0], rng_end[7:0]);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(120, 40) : $urandom_range(12, 1);
      gap = $urandom_range(10, 0);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Sender rests until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (shadow.pending.size() != 0);
  endtask

  // Mostly well-formed commands aimed at live entries; grow phases favor append and
  // insert, shrink phases favor the erases.
  task automatic random_item(input bit grow);
    int unsigned pick;
    int unsigned n;
    int unsigned pos;
    int unsigned span;
    n    = shadow.fill;
    pick = $urandom_range(99, 0);
    pos  = (n == 0) ? 0 : $urandom_range(n - 1, 0);
    if (pick < 8) begin
      offer(3'($urandom_range(7, 0)), $urandom, $urandom, $urandom, $urandom);
    end else if (pick < (grow ? 40 : 22)) begin
      offer(CMD_APPEND, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < (grow ? 70 : 40)) begin
      offer(CMD_INSERT, $urandom_range(n, 0), $urandom, $urandom, $urandom);
    end else if (pick < (grow ? 78 : 62)) begin
      offer(CMD_ERASE_CNT, pos, $urandom,
            ($urandom_range(4, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(3, 0),
            $urandom);
    end else if (pick < (grow ? 86 : 76)) begin
      span = (n > pos) ? $urandom_range((n - pos < 6) ? n - pos : 6, 1) : 1;
      offer(CMD_ERASE_RNG, pos, $urandom, $urandom,
            ($urandom_range(5, 0) == 0) ? $urandom_range(255, 0) : pos + span);
    end else begin
      offer(CMD_READ, ($urandom_range(5, 0) == 0) ? n : pos, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int c;
    int unsigned k;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    burst_left    = 0;
    results_seen  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: every access misses
    offer(CMD_READ, 0, $urandom, $urandom, $urandom);
    offer(CMD_ERASE_CNT, 0, $urandom, 1, $urandom);
    offer(CMD_ERASE_RNG, 0, $urandom, $urandom, 1);
    // value extremes
    offer(CMD_APPEND, $urandom, 32'h8000_0000, $urandom, $urandom);
    offer(CMD_APPEND, $urandom, 32'h7fff_ffff, $urandom, $urandom);
    offer(CMD_APPEND, $urandom, 32'hffff_ffff, $urandom, $urandom);
    // insert at head, at tail, past tail
    offer(CMD_INSERT, 0, 32'h0000_0000, $urandom, $urandom);
    offer(CMD_INSERT, 4, 32'h1234_5678, $urandom, $urandom);
    offer(CMD_INSERT, 255, $urandom, $urandom, $urandom);
    offer(CMD_READ, 0, $urandom, $urandom, $urandom);
    offer(CMD_READ, 4, $urandom, $urandom, $urandom);
    offer(CMD_READ, 255, $urandom, $urandom, $urandom);
    // zero count, clamped count, bad start
    offer(CMD_ERASE_CNT, 1, $urandom, 0, $urandom);
    offer(CMD_ERASE_CNT, 3, $urandom, 255, $urandom);
    offer(CMD_ERASE_CNT, 255, $urandom, 1, $urandom);
    // empty range, end past count, reversed range, then a good one
    offer(CMD_ERASE_RNG, 1, $urandom, $urandom, 1);
    offer(CMD_ERASE_RNG, 0, $urandom, $urandom, 200);
    offer(CMD_ERASE_RNG, 2, $urandom, $urandom, 1);
    offer(CMD_ERASE_RNG, 1, $urandom, $urandom, 2);
    for (c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
      offer(3'(c), $urandom, $urandom, $urandom, $urandom);
    end
    offer(CMD_READ, 1, $urandom, $urandom, $urandom);

    // fill to capacity, poke the full list, then clear it in one range
    while (shadow.fill < CAPACITY) begin
      if ($urandom_range(1, 0) == 0) begin
        offer(CMD_APPEND, $urandom, $urandom, $urandom, $urandom);
      end else begin
        offer(CMD_INSERT, $urandom_range(shadow.fill, 0), $urandom, $urandom, $urandom);
      end
    end
    offer(CMD_APPEND, $urandom, $urandom, $urandom, $urandom);
    offer(CMD_INSERT, 0, $urandom, $urandom, $urandom);
    offer(CMD_INSERT, 200, $urandom, $urandom, $urandom);
    offer(CMD_READ, CAPACITY - 1, $urandom, $urandom, $urandom);
    offer(CMD_READ, CAPACITY, $urandom, $urandom, $urandom);
    offer(CMD_ERASE_RNG, 0, $urandom, $urandom, CAPACITY);
    offer(CMD_READ, 0, $urandom, $urandom, $urandom);
    drain_results();

    for (k = 0; k < RAND_ITEMS; k++) begin
      random_item(((k / PHASE_LEN) % 2) == 0);
      if (k == RAND_ITEMS / 2) drain_results();
    end

    drain_results();
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
